>>> rtl/core/i2cm_pkg.sv
// Shared constants for the I2C master bit engine: sequencer state codes,
// field widths, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int unsigned StateW = 5;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned OpW    = 3;
    localparam int unsigned BitW   = 3;

    // Sequencer state codes
    localparam logic [StateW-1:0] S_IDLE       = 5'd0;
    localparam logic [StateW-1:0] S_START_A    = 5'd1;
    localparam logic [StateW-1:0] S_START_B    = 5'd2;
    localparam logic [StateW-1:0] S_FINISH     = 5'd3;
    localparam logic [StateW-1:0] S_STOP_A     = 5'd4;
    localparam logic [StateW-1:0] S_WR_DATA    = 5'd5;
    localparam logic [StateW-1:0] S_WR_HIGH    = 5'd6;
    localparam logic [StateW-1:0] S_WR_LOW     = 5'd7;
    localparam logic [StateW-1:0] S_RD_HIGH    = 5'd8;
    localparam logic [StateW-1:0] S_RD_SAMPLE  = 5'd9;
    localparam logic [StateW-1:0] S_RD_ACKDATA = 5'd10;
    localparam logic [StateW-1:0] S_RD_ACKHIGH = 5'd11;
    localparam logic [StateW-1:0] S_RD_ACKLOW  = 5'd12;
    localparam logic [StateW-1:0] S_RD_ACKEND  = 5'd13;
    localparam logic [StateW-1:0] S_WA_REL     = 5'd14;
    localparam logic [StateW-1:0] S_WA_HIGH    = 5'd15;
    localparam logic [StateW-1:0] S_WA_POLL    = 5'd16;
    localparam logic [StateW-1:0] S_WA_OK      = 5'd17;
    localparam logic [StateW-1:0] S_WA_STOP    = 5'd18;

    // Command codes
    localparam logic [OpW-1:0] OP_NONE  = 3'd0;
    localparam logic [OpW-1:0] OP_START = 3'd1;
    localparam logic [OpW-1:0] OP_STOP  = 3'd2;
    localparam logic [OpW-1:0] OP_WRITE = 3'd3;
    localparam logic [OpW-1:0] OP_READ  = 3'd4;
    localparam logic [OpW-1:0] OP_WACK  = 3'd5;

    // Register indexes (bit 2 of the byte address)
    localparam logic REG_DELAY_COUNT = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam logic [ByteW-1:0] DELAY_COUNT_RST = 8'd30;
    localparam logic [ByteW-1:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [BitW-1:0]  LAST_BIT        = 3'd7;

endpackage

>>> rtl/core/i2c_master_bit_engine.sv
// I2C master bit engine: tick-driven SCL/SDA sequencer with an APB register port.
// Depends on i2cm_pkg (state codes, command codes, reset values).
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  s_      | in        | s_tvalid/s_tready  | opcode, tx_byte, send_ack, sda_level
//  m_      | out       | m_tvalid/m_tready  | scl, sda_release, busy, done, rx, err
//  apb     | in        | psel/penable       | delay_count @0x0, ack_timeout @0x4
//
// One item per cycle: each accepted item is one bus tick; the sequencer
// state and the result register update together on the accepting edge.
// The result register is the only stage; s_tready is high whenever it is
// empty or being drained, so a stalled m_ side holds the input back.
// Reset (synchronous, aresetn low) idles the sequencer with both lines high.

module i2c_master_bit_engine (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [2:0] opcode, [10:3] tx_byte, [11] send_ack, [12] sda_level
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // m_tdata: [0] scl_level, [1] sda_release, [2] busy_res, [3] done_res,
    //          [11:4] rx_byte, [12] ack_error
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned SW = i2cm_pkg::StateW;
    localparam int unsigned BW = i2cm_pkg::ByteW;

    // Configuration registers
    logic [BW-1:0] delay_count_reg;
    logic [BW-1:0] ack_timeout_reg;

    // Sequencer state
    logic [SW-1:0]             state_reg,  state_next;
    logic [i2cm_pkg::BitW-1:0] bit_reg,    bit_next;
    logic [BW-1:0]             shift_reg,  shift_next;
    logic [BW-1:0]             dly_reg,    dly_next;
    logic [BW-1:0]             poll_reg,   poll_next;
    logic                      scl_reg,    scl_next;
    logic                      sda_reg,    sda_next;
    logic                      ackc_reg,   ackc_next;
    logic [BW-1:0]             rx_reg,     rx_next;
    logic                      err_reg,    err_next;
    logic                      done_next;

    // Result register
    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    logic        accept;
    logic        cfg_wr;
    logic [i2cm_pkg::OpW-1:0] in_op;
    logic [BW-1:0]            in_tx;
    logic                     in_sack;
    logic                     in_sda;
    logic [BW-1:0]            dly_dec;

    assign in_op   = s_tdata[2:0];
    assign in_tx   = s_tdata[10:3];
    assign in_sack = s_tdata[11];
    assign in_sda  = s_tdata[12];

    // Take a new item whenever the result slot is free or emptying
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // APB: always ready, write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == i2cm_pkg::REG_ACK_TIMEOUT) ?
                    {24'd0, ack_timeout_reg} : {24'd0, delay_count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_count_reg <= i2cm_pkg::DELAY_COUNT_RST;
            ack_timeout_reg <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == i2cm_pkg::REG_ACK_TIMEOUT) begin
                ack_timeout_reg <= pwdata[BW-1:0];
            end else begin
                delay_count_reg <= pwdata[BW-1:0];
            end
        end
    end

    assign dly_dec = (dly_reg != '0) ? dly_reg - 1'b1 : '0;

    // Next sequencer state for one tick
    always_comb begin
        state_next = state_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        dly_next   = dly_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ackc_next  = ackc_reg;
        rx_next    = rx_reg;
        err_next   = err_reg;
        done_next  = 1'b0;

        if (state_reg != i2cm_pkg::S_IDLE) begin
            dly_next = dly_dec;
            if (dly_dec == '0) begin
                // Step acts; most steps reload the half-phase delay
                dly_next = delay_count_reg;
                unique case (state_reg)
                    i2cm_pkg::S_START_A: begin
                        sda_next   = 1'b0;
                        state_next = i2cm_pkg::S_START_B;
                    end
                    i2cm_pkg::S_START_B: begin
                        scl_next   = 1'b0;
                        state_next = i2cm_pkg::S_FINISH;
                    end
                    i2cm_pkg::S_FINISH: begin
                        done_next  = 1'b1;
                        state_next = i2cm_pkg::S_IDLE;
                        dly_next   = '0;
                    end
                    i2cm_pkg::S_STOP_A: begin
                        sda_next   = 1'b1;
                        done_next  = 1'b1;
                        state_next = i2cm_pkg::S_IDLE;
                        dly_next   = '0;
                    end
                    i2cm_pkg::S_WR_DATA: begin
                        sda_next   = shift_reg[BW-1];
                        state_next = i2cm_pkg::S_WR_HIGH;
                    end
                    i2cm_pkg::S_WR_HIGH: begin
                        scl_next   = 1'b1;
                        state_next = i2cm_pkg::S_WR_LOW;
                    end
                    i2cm_pkg::S_WR_LOW: begin
                        scl_next   = 1'b0;
                        shift_next = {shift_reg[BW-2:0], 1'b0};
                        if (bit_reg == i2cm_pkg::LAST_BIT) begin
                            sda_next   = 1'b1;
                            state_next = i2cm_pkg::S_FINISH;
                        end else begin
                            bit_next   = bit_reg + 1'b1;
                            state_next = i2cm_pkg::S_WR_DATA;
                        end
                    end
                    i2cm_pkg::S_RD_HIGH: begin
                        scl_next   = 1'b1;
                        state_next = i2cm_pkg::S_RD_SAMPLE;
                    end
                    i2cm_pkg::S_RD_SAMPLE: begin
                        shift_next = {shift_reg[BW-2:0], in_sda};
                        scl_next   = 1'b0;
                        if (bit_reg == i2cm_pkg::LAST_BIT) begin
                            rx_next    = {shift_reg[BW-2:0], in_sda};
                            state_next = i2cm_pkg::S_RD_ACKDATA;
                        end else begin
                            bit_next   = bit_reg + 1'b1;
                            state_next = i2cm_pkg::S_RD_HIGH;
                        end
                    end
                    i2cm_pkg::S_RD_ACKDATA: begin
                        sda_next   = !ackc_reg;
                        state_next = i2cm_pkg::S_RD_ACKHIGH;
                    end
                    i2cm_pkg::S_RD_ACKHIGH: begin
                        scl_next   = 1'b1;
                        state_next = i2cm_pkg::S_RD_ACKLOW;
                    end
                    i2cm_pkg::S_RD_ACKLOW: begin
                        scl_next   = 1'b0;
                        state_next = i2cm_pkg::S_RD_ACKEND;
                    end
                    i2cm_pkg::S_RD_ACKEND: begin
                        sda_next   = 1'b1;
                        done_next  = 1'b1;
                        state_next = i2cm_pkg::S_IDLE;
                        dly_next   = '0;
                    end
                    i2cm_pkg::S_WA_REL: begin
                        sda_next   = 1'b1;
                        state_next = i2cm_pkg::S_WA_HIGH;
                    end
                    i2cm_pkg::S_WA_HIGH: begin
                        // First poll on the very next tick
                        scl_next   = 1'b1;
                        dly_next   = '0;
                        state_next = i2cm_pkg::S_WA_POLL;
                    end
                    i2cm_pkg::S_WA_POLL: begin
                        if (!in_sda) begin
                            scl_next   = 1'b0;
                            state_next = i2cm_pkg::S_WA_OK;
                        end else if (poll_reg >= ack_timeout_reg) begin
                            // Give up: drive SDA low under high SCL, then stop
                            sda_next   = 1'b0;
                            scl_next   = 1'b1;
                            state_next = i2cm_pkg::S_WA_STOP;
                        end else begin
                            poll_next  = poll_reg + 1'b1;
                        end
                    end
                    i2cm_pkg::S_WA_OK: begin
                        err_next   = 1'b0;
                        done_next  = 1'b1;
                        state_next = i2cm_pkg::S_IDLE;
                        dly_next   = '0;
                    end
                    i2cm_pkg::S_WA_STOP: begin
                        sda_next   = 1'b1;
                        err_next   = 1'b1;
                        done_next  = 1'b1;
                        state_next = i2cm_pkg::S_IDLE;
                        dly_next   = '0;
                    end
                    default: begin
                        // Unused codes drop back to idle silently
                        state_next = i2cm_pkg::S_IDLE;
                        dly_next   = '0;
                    end
                endcase
            end
        end else begin
            unique case (in_op)
                i2cm_pkg::OP_START: begin
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    dly_next   = delay_count_reg;
                    state_next = i2cm_pkg::S_START_A;
                end
                i2cm_pkg::OP_STOP: begin
                    sda_next   = 1'b0;
                    scl_next   = 1'b1;
                    dly_next   = delay_count_reg;
                    state_next = i2cm_pkg::S_STOP_A;
                end
                i2cm_pkg::OP_WRITE: begin
                    // Load the byte and put out its first bit on this tick
                    shift_next = in_tx;
                    bit_next   = '0;
                    sda_next   = in_tx[BW-1];
                    dly_next   = delay_count_reg;
                    state_next = i2cm_pkg::S_WR_HIGH;
                end
                i2cm_pkg::OP_READ: begin
                    // Release SDA and raise SCL for the first bit at once
                    shift_next = '0;
                    bit_next   = '0;
                    ackc_next  = in_sack;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    dly_next   = delay_count_reg;
                    state_next = i2cm_pkg::S_RD_SAMPLE;
                end
                i2cm_pkg::OP_WACK: begin
                    poll_next  = '0;
                    scl_next   = 1'b0;
                    dly_next   = delay_count_reg;
                    state_next = i2cm_pkg::S_WA_REL;
                end
                default: begin
                    // No command, or a code without meaning: stay idle
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2cm_pkg::S_IDLE;
            bit_reg   <= '0;
            shift_reg <= '0;
            dly_reg   <= '0;
            poll_reg  <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ackc_reg  <= 1'b0;
            rx_reg    <= '0;
            err_reg   <= 1'b0;
        end else if (accept) begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            dly_reg   <= dly_next;
            poll_reg  <= poll_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ackc_reg  <= ackc_next;
            rx_reg    <= rx_next;
            err_reg   <= err_next;
        end
    end

    // Result slot: load on accept, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {3'd0, err_next, rx_next, done_next,
                           (state_next != i2cm_pkg::S_IDLE), sda_next, scl_next};
        end
    end

endmodule
